### rtl/alpl_pkg.sv
// Package for the arc-length parameter lookup block.
// Holds table geometry, field widths, register indexes and reset values.
// Depends on nothing; imported by arc_length_param_lookup_top.
package alpl_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = TBL_AW + 1;

  // Field widths: distances Q16.8, parameters Q8.16.
  localparam int DATA_W = 24;
  localparam int PC_W   = 8;

  // Interpolation datapath widths.
  localparam int UA_W    = DATA_W;          // |query - d0|
  localparam int UB_W    = DATA_W + 1;      // |p1 - p0| with wrap
  localparam int UD_W    = DATA_W + 1;      // |d1 - d0| with wrap
  localparam int PROD_W  = UA_W + UB_W;     // product and quotient
  localparam int DIV_CW  = $clog2(PROD_W);

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENTRY_COUNT  = 2'd0;
  localparam logic [1:0] CFG_TRACK_LENGTH = 2'd1;
  localparam logic [1:0] CFG_POINT_COUNT  = 2'd2;

  // Configuration reset values and limits.
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(2);
  localparam logic [CNT_W-1:0] ENTRY_COUNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] ENTRY_COUNT_MAX = CNT_W'(TABLE_DEPTH);
  localparam logic [PC_W-1:0]  POINT_COUNT_RST = PC_W'(3);

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

### rtl/arc_length_param_lookup_top.sv
// Arc-length parameter lookup: table memories, binary search, interpolation.
// A single sequencer drives one table read port and a shared one-bit divider.
// Depends on alpl_pkg.

// A write item (in_cmd low) stores one table entry at the accepting edge,
// produces no result and leaves busy low, so items may follow back to back.
// A query item raises busy and runs k binary search steps, where k is 1 to 10:
// each step takes a read state and a compare state because the table has one
// registered read port. The restoring divider then retires one quotient bit
// per cycle. A query that lands on a zero-width interval skips the multiply
// and divide.
// The result appears on out_curve_position and out_range_flag for exactly
// one cycle with out_valid high; the receiver cannot stall it, and busy falls
// in that same cycle so the next item can be started at once. Table contents
// are undefined until written; configuration must be written only while busy
// is low.
module arc_length_param_lookup_top
  import alpl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Command channel
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [TBL_AW-1:0] in_entry_index,
  input  logic [DATA_W-1:0] in_entry_distance,
  input  logic [DATA_W-1:0] in_entry_position,
  input  logic [DATA_W-1:0] in_query_distance,
  // Result channel
  output logic              out_valid,
  output logic [DATA_W-1:0] out_curve_position,
  output logic              out_range_flag,
  // Configuration port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;  // search read
  localparam logic [2:0] S_SCMP = 3'd2;  // search compare
  localparam logic [2:0] S_RD0  = 3'd3;  // read lower entry
  localparam logic [2:0] S_RD1  = 3'd4;  // read upper entry
  localparam logic [2:0] S_PREP = 3'd5;  // differences and signs
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_DIV  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       fin_r;

  // Configuration registers.
  logic [CNT_W-1:0]  entry_count_r;
  logic [DATA_W-1:0] track_length_r;
  logic [PC_W-1:0]   point_count_r;

  // Table memories and their registered read data.
  logic [DATA_W-1:0] dist_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] pos_mem  [TABLE_DEPTH];
  logic [DATA_W-1:0] dist_rd_r, pos_rd_r;
  logic [TBL_AW-1:0] rd_addr;
  logic              mem_we;

  // Search and interpolation registers.
  logic [DATA_W-1:0] query_r;
  logic [CNT_W-1:0]  n_r, lo_r, hi_r, cur_r;
  logic              wrap_r;
  logic [DATA_W-1:0] d0_r, p0_r;
  logic [UA_W-1:0]   ua_r;
  logic [UB_W-1:0]   ub_r;
  logic [UD_W-1:0]   ud_r;
  logic              neg_r, zero_r;
  logic [PROD_W-1:0] quo_r;
  logic [UD_W-1:0]   rem_r;
  logic [DIV_CW-1:0] div_cnt_r;

  // Output registers.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_pos_r;
  logic              out_flag_r;

  logic              accept;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  lo_new, hi_new, cur_new;
  logic [CNT_W-1:0]  nxt_idx;
  logic [DATA_W:0]   d1_w, p1_w;
  logic [DATA_W:0]   a_s;
  logic [DATA_W+1:0] b_s, den_s;
  logic [UD_W:0]     trial;
  logic [DATA_W+2:0] sum_s;
  logic              big_mag;

  assign accept = start && !busy;
  assign mem_we = accept && (in_cmd == CMD_WRITE);
  assign busy   = (state_r != S_IDLE) || fin_r;

  // Clamp the entry count to the usable table size.
  always_comb begin
    n_eff = entry_count_r;
    if (entry_count_r < ENTRY_COUNT_MIN) begin
      n_eff = ENTRY_COUNT_MIN;
    end else if (entry_count_r > ENTRY_COUNT_MAX) begin
      n_eff = ENTRY_COUNT_MAX;
    end
  end

  // One halving step of the search.
  always_comb begin
    lo_new = lo_r;
    hi_new = hi_r;
    if (query_r <= dist_rd_r) begin
      hi_new = cur_r;
    end else begin
      lo_new = cur_r;
    end
    mid_sum = {1'b0, lo_new} + {1'b0, hi_new};
    cur_new = mid_sum[CNT_W:1];
  end

  // Upper entry of the interval wraps to entry zero past the last one.
  assign nxt_idx = (cur_r + CNT_W'(1) == n_r) ? '0 : cur_r + CNT_W'(1);
  assign rd_addr = (state_r == S_RD1) ? nxt_idx[TBL_AW-1:0] : cur_r[TBL_AW-1:0];

  // Wrapped end point and signed differences.
  assign d1_w  = {1'b0, dist_rd_r} + (wrap_r ? {1'b0, track_length_r} : '0);
  assign p1_w  = {1'b0, pos_rd_r} + (wrap_r ? {1'b0, point_count_r, 16'h0000} : '0);
  assign a_s   = {1'b0, query_r} - {1'b0, d0_r};
  assign b_s   = {1'b0, p1_w} - {2'b00, p0_r};
  assign den_s = {1'b0, d1_w} - {2'b00, d0_r};

  // Restoring division trial subtraction.
  assign trial = {rem_r, quo_r[PROD_W-1]} - {1'b0, ud_r};

  // Final add or subtract of the quotient against the lower parameter.
  assign big_mag = |quo_r[PROD_W-1:DATA_W+1];
  assign sum_s   = neg_r ? ({3'b000, p0_r} - {2'b00, quo_r[DATA_W:0]})
                         : ({3'b000, p0_r} + {2'b00, quo_r[DATA_W:0]});

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_QUERY)) begin
          state_nxt = S_SRD;
        end
      end
      S_SRD:  state_nxt = S_SCMP;
      S_SCMP: state_nxt = (lo_new < cur_new) ? S_SRD : S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_PREP;
      S_PREP: state_nxt = (den_s == '0) ? S_IDLE : S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  state_nxt = (div_cnt_r == DIV_CW'(PROD_W - 1)) ? S_IDLE : S_DIV;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      fin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      entry_count_r  <= ENTRY_COUNT_RST;
      track_length_r <= '0;
      point_count_r  <= POINT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= ((state_r == S_PREP) && (den_s == '0)) ||
                     ((state_r == S_DIV) && (div_cnt_r == DIV_CW'(PROD_W - 1)));
      out_valid_r <= fin_r;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT:  entry_count_r  <= cfg_wdata[CNT_W-1:0];
          CFG_TRACK_LENGTH: track_length_r <= cfg_wdata;
          CFG_POINT_COUNT:  point_count_r  <= cfg_wdata[PC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Table memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dist_mem[in_entry_index] <= in_entry_distance;
      pos_mem[in_entry_index]  <= in_entry_position;
    end
    dist_rd_r <= dist_mem[rd_addr];
    pos_rd_r  <= pos_mem[rd_addr];
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        query_r <= in_query_distance;
        n_r     <= n_eff;
        lo_r    <= '0;
        hi_r    <= n_eff;
        cur_r   <= {1'b0, n_eff[CNT_W-1:1]};
      end
      S_SCMP: begin
        lo_r  <= lo_new;
        hi_r  <= hi_new;
        cur_r <= cur_new;
      end
      S_RD0: begin
        wrap_r <= (cur_r == n_r - CNT_W'(1));
      end
      S_RD1: begin
        d0_r <= dist_rd_r;
        p0_r <= pos_rd_r;
      end
      S_PREP: begin
        zero_r    <= (den_s == '0);
        ua_r      <= a_s[DATA_W] ? UA_W'(-a_s) : a_s[UA_W-1:0];
        ub_r      <= b_s[DATA_W+1] ? UB_W'(-b_s) : b_s[UB_W-1:0];
        ud_r      <= den_s[DATA_W+1] ? UD_W'(-den_s) : den_s[UD_W-1:0];
        neg_r     <= a_s[DATA_W] ^ b_s[DATA_W+1] ^ den_s[DATA_W+1];
        div_cnt_r <= '0;
      end
      S_MUL: begin
        quo_r <= PROD_W'(ua_r) * PROD_W'(ub_r);
        rem_r <= '0;
      end
      S_DIV: begin
        div_cnt_r <= div_cnt_r + DIV_CW'(1);
        if (!trial[UD_W]) begin
          rem_r <= trial[UD_W-1:0];
          quo_r <= {quo_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[UD_W-2:0], quo_r[PROD_W-1]};
          quo_r <= {quo_r[PROD_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Result register: lower parameter on a zero-width interval, else saturate to the unsigned 24-bit range.
  always_ff @(posedge clk) begin
    if (fin_r) begin
      if (zero_r) begin
        out_pos_r  <= p0_r;
        out_flag_r <= 1'b1;
      end else if (big_mag) begin
        out_pos_r  <= neg_r ? '0 : '1;
        out_flag_r <= 1'b1;
      end else if (sum_s[DATA_W+2]) begin
        out_pos_r  <= '0;
        out_flag_r <= 1'b1;
      end else if (|sum_s[DATA_W+1:DATA_W]) begin
        out_pos_r  <= '1;
        out_flag_r <= 1'b1;
      end else begin
        out_pos_r  <= sum_s[DATA_W-1:0];
        out_flag_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_curve_position = out_pos_r;
  assign out_range_flag     = out_flag_r;

  // A result is only shown in the cycle after a query has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(fin_r))
    else $error("result strobe without a finished query");

  // An accepted query makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // The search probe always lies strictly inside its bounds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> ((lo_r < cur_r) && (cur_r < hi_r)))
    else $error("search probe outside its bounds");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < ud_r))
    else $error("divider remainder not below divisor");

endmodule
